// ===== hw/rtl/texture_sampler_wrap_bilinear_core_macros.svh =====
// Assertion macros used by the texture sampler top level.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TEXTURE_SAMPLER_WRAP_BILINEAR_CORE_MACROS_SVH
`define TEXTURE_SAMPLER_WRAP_BILINEAR_CORE_MACROS_SVH

// Same-cycle implication.
`define TSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tsw_pkg.sv =====
// Package for the texture sampler: widths, codes and shared structs.
// No dependencies.
package tsw_pkg;

    localparam int DEF_MAX_WIDTH        = 256;
    localparam int DEF_MAX_HEIGHT       = 256;
    localparam int DEF_WEIGHT_FRAC_BITS = 8;

    localparam int DIM_W      = 9;
    localparam int COORD_W    = 21;
    localparam int TEXEL_W    = 32;
    localparam int INDEX_W    = 16;
    localparam int AIW_W      = 14;
    localparam int AFW_W      = 25;
    localparam int DIST_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAX_ADDR_W = 24;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic FILTER_NEAREST  = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;

    typedef enum logic [1:0] {
        WRAP_REPEAT     = 2'd0,
        WRAP_CLAMP_EDGE = 2'd1,
        WRAP_MIRROR     = 2'd2,
        WRAP_BORDER     = 2'd3
    } wrap_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH    = 3'd0,
        CFG_TEX_HEIGHT   = 3'd1,
        CFG_WRAP_MODE    = 3'd2,
        CFG_FILTER_MODE  = 3'd3,
        CFG_BORDER_COLOR = 3'd4
    } cfg_index_t;

    // Scaled coordinate split into integer and fraction products.
    typedef struct packed {
        logic             sgn;
        logic             par;
        logic [AIW_W-1:0] aiw;
        logic [AFW_W-1:0] afw;
    } axis_pre_t;

    // Wrapped base and neighbor texel on one axis.
    typedef struct packed {
        logic [DIM_W-1:0]  c0;
        logic [DIM_W-1:0]  c1;
        logic              in0;
        logic              in1;
        logic [DIST_W-1:0] span;
    } axis_map_t;

    typedef struct packed {
        logic                              we;
        logic [MAX_ADDR_W-1:0]             waddr;
        logic [TEXEL_W-1:0]                wdata;
        logic [3:0][MAX_ADDR_W-1:0]        raddr;
    } mem_req_t;

endpackage

// ===== hw/rtl/tsw_axis.sv =====
// Per-axis coordinate mapping: base texel, neighbor, wrap mode, distance.
// Depends on tsw_pkg.
module tsw_axis (
    input  tsw_pkg::axis_pre_t          pre,
    input  logic [tsw_pkg::DIM_W-1:0]   size,
    input  tsw_pkg::wrap_mode_t         wrap,
    output tsw_pkg::axis_map_t          map
);
    import tsw_pkg::*;

    typedef struct packed {
        logic [DIM_W-1:0] c;
        logic             inr;
    } wrapped_t;

    logic [DIM_W-1:0]     t;
    logic [15:0]          fr;
    logic                 up;
    logic [14:0]          mag;
    logic signed [15:0]   x0;
    logic signed [15:0]   x1;
    logic signed [11:0]   ts;
    logic signed [11:0]   off;
    wrapped_t             r0;
    wrapped_t             r1;

    function automatic wrapped_t wrap_one(input logic signed [15:0] c,
                                          input logic signed [11:0] tt,
                                          input logic [DIM_W-1:0] n,
                                          input logic par,
                                          input wrap_mode_t mode);
        logic signed [11:0] sn;
        logic signed [11:0] sn2;
        logic signed [11:0] m0;
        logic signed [11:0] m;
        logic signed [15:0] n16;
        wrapped_t           res;
        sn  = $signed({3'b000, n});
        sn2 = sn <<< 1;
        n16 = $signed({7'd0, n});
        res.c   = '0;
        res.inr = 1'b1;
        case (mode)
            WRAP_REPEAT:
            begin
                if (tt < 0)
                    m = tt + sn;
                else if (tt >= sn)
                    m = tt - sn;
                else
                    m = tt;
                res.c = m[DIM_W-1:0];
            end
            WRAP_CLAMP_EDGE:
            begin
                if (c < 0)
                    res.c = '0;
                else if (c >= n16)
                    res.c = n - 9'd1;
                else
                    res.c = c[DIM_W-1:0];
            end
            WRAP_MIRROR:
            begin
                m0 = tt + (par ? sn : 12'sd0);
                if (m0 < 0)
                    m = m0 + sn2;
                else if (m0 >= sn2)
                    m = m0 - sn2;
                else
                    m = m0;
                if (m >= sn)
                    m = sn2 - 12'sd1 - m;
                res.c = m[DIM_W-1:0];
            end
            default:
            begin
                res.inr = (c >= 0) && (c < n16);
                res.c   = res.inr ? c[DIM_W-1:0] : '0;
            end
        endcase
        return res;
    endfunction

    always_comb
    begin
        t   = pre.afw[AFW_W-1:16];
        fr  = pre.afw[15:0];
        up  = !pre.sgn && fr[15];
        mag = 15'(pre.aiw) + 15'(t);
        x0  = pre.sgn ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        off = up ? 12'sd1 : -12'sd1;
        x1  = x0 + 16'(off);
        ts  = pre.sgn ? -$signed({3'b000, t}) : $signed({3'b000, t});
        r0  = wrap_one(x0, ts, size, pre.par, wrap);
        r1  = wrap_one(x1, ts + off, size, pre.par, wrap);
        map.c0  = r0.c;
        map.in0 = r0.inr;
        map.c1  = r1.c;
        map.in1 = r1.inr;
        if (up)
            map.span = {1'b0, fr} - 17'd32768;
        else if (pre.sgn)
            map.span = 17'd32768 + {1'b0, fr};
        else
            map.span = 17'd32768 - {1'b0, fr};
    end

endmodule

// ===== hw/rtl/tsw_mem.sv =====
// Texel store: two copies, each written together and read at two addresses.
// Depends on tsw_pkg.
module tsw_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  tsw_pkg::mem_req_t                 req,
    output logic [3:0][tsw_pkg::TEXEL_W-1:0]  rdata
);
    import tsw_pkg::*;

    logic [TEXEL_W-1:0] mem_a [DEPTH];
    logic [TEXEL_W-1:0] mem_b [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (req.we)
            begin
                mem_a[req.waddr[AW-1:0]] <= req.wdata;
                mem_b[req.waddr[AW-1:0]] <= req.wdata;
            end
            rdata[0] <= mem_a[req.raddr[0][AW-1:0]];
            rdata[1] <= mem_a[req.raddr[1][AW-1:0]];
            rdata[2] <= mem_b[req.raddr[2][AW-1:0]];
            rdata[3] <= mem_b[req.raddr[3][AW-1:0]];
        end
    end

endmodule

// ===== hw/rtl/tsw_blend.sv =====
// Bilinear blend: per-channel weight products, then sum, round and clamp.
// Depends on tsw_pkg; holds the output register.
module tsw_blend #(
    parameter int WEIGHT_FRAC_BITS = 8,
    parameter int WT_W             = 2 * WEIGHT_FRAC_BITS + 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0][tsw_pkg::TEXEL_W-1:0]    texel,
    input  logic [3:0]                          inb,
    input  logic [tsw_pkg::TEXEL_W-1:0]         border,
    input  logic signed [WT_W-1:0]              wt [4],
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata  // red, green, blue, alpha
);
    import tsw_pkg::*;

    localparam int PW  = WT_W + 9;
    localparam int ACW = PW + 3;
    localparam int SH  = 2 * WEIGHT_FRAC_BITS;

    logic                 prod_v_reg;
    logic signed [PW-1:0] prod_reg  [4][4];
    logic signed [PW-1:0] prod_next [4][4];
    logic                 ok_prod;
    logic                 ok_out;
    logic [31:0]          out_next;
    logic [TEXEL_W-1:0]   tsel;
    logic signed [PW-1:0] ce;
    logic signed [PW-1:0] we;
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] r;

    assign ok_out   = !m_tvalid || m_tready;
    assign ok_prod  = !prod_v_reg || ok_out;
    assign in_ready = ok_prod;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            tsel = inb[k] ? texel[k] : border;
            for (int c = 0; c < 4; c++)
            begin
                ce = PW'(tsel[8*c +: 8]);
                we = PW'(wt[k]);
                prod_next[c][k] = ce * we;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc = ACW'(1) <<< (SH - 1);
            for (int k = 0; k < 4; k++)
                acc = acc + ACW'(prod_reg[c][k]);
            r = acc >>> SH;
            if (acc < 0)
                out_next[8*c +: 8] = 8'd0;
            else if (r > 255)
                out_next[8*c +: 8] = 8'd255;
            else
                out_next[8*c +: 8] = r[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            m_tvalid   <= 1'b0;
        end
        else
        begin
            if (ok_prod)
                prod_v_reg <= in_valid;
            if (ok_out)
                m_tvalid <= prod_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ok_prod)
            prod_reg <= prod_next;
        if (ok_out)
            m_tdata <= out_next;
    end

endmodule

// ===== hw/rtl/texture_sampler_wrap_bilinear_core.sv =====
// Texture sampler top level: input pipeline, texel store and blend.
// Depends on tsw_pkg, tsw_axis, tsw_mem, tsw_blend and the macro header.
// One item is accepted per cycle when the output is taken; a sample result
// passes through registered stages for coordinate scale, wrap, address and
// weights, store read, channel products, and sum and clamp.
// Texel writes give no result and update the store at the read stage, so
// any later sample sees them. Unwritten texels read undefined.
`include "texture_sampler_wrap_bilinear_core_macros.svh"
module texture_sampler_wrap_bilinear_core #(
    parameter int WEIGHT_FRAC_BITS = tsw_pkg::DEF_WEIGHT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [95:0]                       s_tdata,  // texel_index, texel_value, coord_u, coord_v
    input  logic [0:0]                        s_tuser,  // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // out_red, out_green, out_blue, out_alpha
    input  logic                              cfg_we,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tsw_pkg::*;

    localparam int MAX_WIDTH  = DEF_MAX_WIDTH;
    localparam int MAX_HEIGHT = DEF_MAX_HEIGHT;
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(DEPTH);
    localparam int F    = WEIGHT_FRAC_BITS;
    localparam int SXW  = F + 1;
    localparam int FW   = F + 2;
    localparam int WT_W = 2 * F + 4;

    // configuration
    logic [DIM_W-1:0]   tex_width_reg;
    logic [DIM_W-1:0]   tex_height_reg;
    wrap_mode_t         wrap_mode_reg;
    logic               filter_mode_reg;
    logic [TEXEL_W-1:0] border_color_reg;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;

    // input fields
    logic                      in_op;
    logic [INDEX_W-1:0]        in_idx;
    logic [TEXEL_W-1:0]        in_val;
    logic signed [COORD_W-1:0] in_u;
    logic signed [COORD_W-1:0] in_v;
    logic [COORD_W-1:0]        au;
    logic [COORD_W-1:0]        av;

    logic ok1, ok2, ok3, ok4;
    logic blend_ready;

    // stage 1
    logic               v1, op1, wr1;
    logic [AW-1:0]      idx1;
    logic [TEXEL_W-1:0] val1;
    axis_pre_t          preu1, prev1;
    axis_pre_t          preu_next, prev_next;

    // stage 2
    logic               v2, op2, wr2;
    logic [AW-1:0]      idx2;
    logic [TEXEL_W-1:0] val2;
    axis_map_t          mu_comb, mv_comb;
    axis_map_t          mu2, mv2;
    logic [SXW-1:0]     sx2, sy2;

    // stage 3
    logic                       v3, op3, wr3;
    logic [AW-1:0]              idx3;
    logic [TEXEL_W-1:0]         val3;
    logic [MAX_ADDR_W-1:0]      raddr3 [4];
    logic [3:0]                 inb3;
    logic signed [WT_W-1:0]     wt3 [4];
    logic [MAX_ADDR_W-1:0]      raddr_next [4];
    logic [3:0]                 inb_next;
    logic signed [WT_W-1:0]     wt_next [4];
    logic signed [FW-1:0]       fx0, fx1, fy0, fy1;
    logic [17:0]                rowp;
    logic                       bil;

    // stage 4
    logic                       v4;
    logic [3:0]                 inb4;
    logic signed [WT_W-1:0]     wt4 [4];
    logic [3:0][TEXEL_W-1:0]    rdata;
    mem_req_t                   req;

    assign in_idx = s_tdata[15:0];
    assign in_val = s_tdata[47:16];
    assign in_u   = $signed(s_tdata[68:48]);
    assign in_v   = $signed(s_tdata[89:69]);
    assign in_op  = s_tuser[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg    <= 9'd256;
            tex_height_reg   <= 9'd256;
            wrap_mode_reg    <= WRAP_REPEAT;
            filter_mode_reg  <= FILTER_NEAREST;
            border_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:    tex_width_reg    <= cfg_wdata[DIM_W-1:0];
                CFG_TEX_HEIGHT:   tex_height_reg   <= cfg_wdata[DIM_W-1:0];
                CFG_WRAP_MODE:    wrap_mode_reg    <= wrap_mode_t'(cfg_wdata[1:0]);
                CFG_FILTER_MODE:  filter_mode_reg  <= cfg_wdata[0];
                CFG_BORDER_COLOR: border_color_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (tex_width_reg == '0)
            w_eff = 9'd1;
        else if (32'(tex_width_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = tex_width_reg;
        if (tex_height_reg == '0)
            h_eff = 9'd1;
        else if (32'(tex_height_reg) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = tex_height_reg;
    end

    assign ok4 = !v4 || blend_ready;
    assign ok3 = !v3 || ok4;
    assign ok2 = !v2 || ok3;
    assign ok1 = !v1 || ok2;
    assign s_tready = ok1;

    // stage 1: magnitude times size
    always_comb
    begin
        au = in_u[COORD_W-1] ? COORD_W'(-in_u) : COORD_W'(in_u);
        av = in_v[COORD_W-1] ? COORD_W'(-in_v) : COORD_W'(in_v);
        preu_next.sgn = in_u[COORD_W-1];
        preu_next.par = au[16];
        preu_next.aiw = AIW_W'(au[20:16]) * AIW_W'(w_eff);
        preu_next.afw = AFW_W'(au[15:0]) * AFW_W'(w_eff);
        prev_next.sgn = in_v[COORD_W-1];
        prev_next.par = av[16];
        prev_next.aiw = AIW_W'(av[20:16]) * AIW_W'(h_eff);
        prev_next.afw = AFW_W'(av[15:0]) * AFW_W'(h_eff);
    end

    // stage 2: wrap
    tsw_axis u_axis_u (
        .pre  (preu1),
        .size (w_eff),
        .wrap (wrap_mode_reg),
        .map  (mu_comb)
    );

    tsw_axis u_axis_v (
        .pre  (prev1),
        .size (h_eff),
        .wrap (wrap_mode_reg),
        .map  (mv_comb)
    );

    // stage 3: addresses and weights
    always_comb
    begin
        bil  = (filter_mode_reg == FILTER_BILINEAR);
        rowp = 18'(mv2.c0) * 18'(w_eff);
        raddr_next[0] = MAX_ADDR_W'(19'(rowp) + 19'(mu2.c0));
        raddr_next[2] = MAX_ADDR_W'(19'(rowp) + 19'(mu2.c1));
        rowp = 18'(mv2.c1) * 18'(w_eff);
        raddr_next[1] = MAX_ADDR_W'(19'(rowp) + 19'(mu2.c0));
        raddr_next[3] = MAX_ADDR_W'(19'(rowp) + 19'(mu2.c1));
        // neighbor taps carry zero weight in nearest mode; their store data is not selected
        inb_next[0] = mu2.in0 && mv2.in0;
        inb_next[1] = mu2.in0 && mv2.in1 && bil;
        inb_next[2] = mu2.in1 && mv2.in0 && bil;
        inb_next[3] = mu2.in1 && mv2.in1 && bil;
        fx1 = $signed({1'b0, sx2});
        fy1 = $signed({1'b0, sy2});
        fx0 = (FW'(1) <<< F) - fx1;
        fy0 = (FW'(1) <<< F) - fy1;
        wt_next[0] = WT_W'(fx0) * WT_W'(fy0);
        wt_next[1] = WT_W'(fx0) * WT_W'(fy1);
        wt_next[2] = WT_W'(fx1) * WT_W'(fy0);
        wt_next[3] = WT_W'(fx1) * WT_W'(fy1);
    end

    always_comb
    begin
        req.we    = v3 && (op3 == OP_WRITE) && wr3;
        req.waddr = MAX_ADDR_W'(idx3);
        req.wdata = val3;
        for (int k = 0; k < 4; k++)
            req.raddr[k] = raddr3[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1 <= 1'b0;
            v2 <= 1'b0;
            v3 <= 1'b0;
            v4 <= 1'b0;
        end
        else
        begin
            if (ok1)
                v1 <= s_tvalid;
            if (ok2)
                v2 <= v1;
            if (ok3)
                v3 <= v2;
            if (ok4)
                v4 <= v3 && (op3 == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ok1)
        begin
            op1   <= in_op;
            wr1   <= 32'(in_idx) < DEPTH;
            idx1  <= AW'(in_idx);
            val1  <= in_val;
            preu1 <= preu_next;
            prev1 <= prev_next;
        end
        if (ok2)
        begin
            op2  <= op1;
            wr2  <= wr1;
            idx2 <= idx1;
            val2 <= val1;
            mu2  <= mu_comb;
            mv2  <= mv_comb;
            sx2  <= (filter_mode_reg == FILTER_BILINEAR) ?
                    SXW'(mu_comb.span >> (16 - F)) : '0;
            sy2  <= (filter_mode_reg == FILTER_BILINEAR) ?
                    SXW'(mv_comb.span >> (16 - F)) : '0;
        end
        if (ok3)
        begin
            op3    <= op2;
            wr3    <= wr2;
            idx3   <= idx2;
            val3   <= val2;
            raddr3 <= raddr_next;
            inb3   <= inb_next;
            wt3    <= wt_next;
        end
        if (ok4)
        begin
            inb4 <= inb3;
            wt4  <= wt3;
        end
    end

    tsw_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .en    (ok4),
        .req   (req),
        .rdata (rdata)
    );

    tsw_blend #(
        .WEIGHT_FRAC_BITS (F),
        .WT_W             (WT_W)
    ) u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v4),
        .in_ready (blend_ready),
        .texel    (rdata),
        .inb      (inb4),
        .border   (border_color_reg),
        .wt       (wt4),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `TSW_ASSERT_NEXT(a_write_gives_no_result, ok4 && v3 && (op3 == OP_WRITE), !v4, "write reached blend")
    `TSW_ASSERT_NEXT(a_sample_reaches_read, ok4 && v3 && (op3 == OP_SAMPLE), v4, "sample dropped at read")
    `TSW_ASSERT_NOW(a_read_addr_range, v3 && (op3 == OP_SAMPLE), (32'(raddr3[0]) < DEPTH) && (32'(raddr3[1]) < DEPTH) && (32'(raddr3[2]) < DEPTH) && (32'(raddr3[3]) < DEPTH), "read address out of store")

endmodule
